// File: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types for the bounded deque: request codes, status codes, the
// controller states and the result word.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL_DROP = 2'd1,
        ST_EMPTY_POP = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                 found;
        logic [POS_W-1:0]     match_position;
        logic [COUNT_W-1:0]   entry_count;
        t_status              status;
    } t_result;

endpackage

// File: rtl/core/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq_req_if / bdq_rsp_if
// Valid/ready channels of the deque: request words in, result words out.
// ----------------------------------------------------------------------------
interface bdq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [bdq_pkg::CMD_W-1:0]            cmd;
    logic signed [bdq_pkg::VALUE_W-1:0]   item_value;

    modport source (output valid, output cmd, output item_value, input ready);
    modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface bdq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic [bdq_pkg::POS_W-1:0]            match_position;
    logic [bdq_pkg::COUNT_W-1:0]          entry_count;
    logic [bdq_pkg::STATUS_W-1:0]         status;

    modport source (output valid, output found, output match_position,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input found, input match_position,
                    input entry_count, input status, output ready);
endinterface

// File: rtl/core/bdq_store.sv
// ----------------------------------------------------------------------------
// bdq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [DATA_WIDTH-1:0]         i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [DATA_WIDTH-1:0]         o_rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// File: rtl/core/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Front index and count, request decode, search sequencer over the entry
// memory, and the result output register.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bdq_req_if.sink                   i_req,
    bdq_rsp_if.source                 o_rsp,
    output logic                      o_mem_we,
    output logic [$clog2(DEPTH)-1:0]  o_mem_waddr,
    output logic [DATA_WIDTH-1:0]     o_mem_wdata,
    output logic                      o_mem_re,
    output logic [$clog2(DEPTH)-1:0]  o_mem_raddr,
    input  logic [DATA_WIDTH-1:0]     i_mem_rdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S  = (CW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    // ring position of base + off, both operands below 2*DEPTH in sum
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return IW'(s);
    endfunction

    bdq_pkg::t_state  r_state, n_state;
    logic [IW-1:0]    r_front, n_front;
    logic [CW-1:0]    r_count, n_count;
    logic [DATA_WIDTH-1:0] r_word;
    logic [CW-1:0]    r_iss;
    logic [IW-1:0]    r_cpos;
    logic             r_cmp_v;
    bdq_pkg::t_result r_res, op_res;
    bdq_pkg::t_result r_out;
    logic             r_ovalid;

    bdq_pkg::t_cmd    cmd;
    logic             accept;
    logic             is_full, is_empty;
    logic [IW-1:0]    front_dec;
    logic [DATA_WIDTH-1:0] in_word;
    logic             hit, more, out_free, out_load;

    assign cmd       = bdq_pkg::t_cmd'(i_req.cmd);
    assign accept    = i_req.valid && i_req.ready;
    assign in_word   = DATA_WIDTH'(i_req.item_value);
    assign is_full   = (r_count == DEPTH_C);
    assign is_empty  = (r_count == '0);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - 1'b1;

    assign hit      = r_cmp_v && (i_mem_rdata == r_word);
    assign more     = (r_iss < r_count);
    assign out_free = !r_ovalid || o_rsp.ready;

    // request decode: every operation but search completes on acceptance
    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_front;
        o_mem_wdata = in_word;
        op_res      = '{found: 1'b0, match_position: '0, entry_count: '0,
                        status: bdq_pkg::ST_DONE};
        if (accept) begin
            unique case (cmd)
                bdq_pkg::CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        op_res.status = bdq_pkg::ST_FULL_DROP;
                    end else begin
                        n_front     = front_dec;
                        n_count     = r_count + 1'b1;
                        o_mem_we    = 1'b1;
                        o_mem_waddr = front_dec;
                    end
                end
                bdq_pkg::CMD_PUSH_BACK: begin
                    if (is_full) begin
                        op_res.status = bdq_pkg::ST_FULL_DROP;
                    end else begin
                        n_count     = r_count + 1'b1;
                        o_mem_we    = 1'b1;
                        o_mem_waddr = ring_add(r_front, r_count);
                    end
                end
                bdq_pkg::CMD_POP_FRONT: begin
                    if (is_empty) begin
                        op_res.status = bdq_pkg::ST_EMPTY_POP;
                    end else begin
                        n_front = ring_add(r_front, CW'(1));
                        n_count = r_count - 1'b1;
                    end
                end
                bdq_pkg::CMD_POP_BACK: begin
                    if (is_empty) begin
                        op_res.status = bdq_pkg::ST_EMPTY_POP;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                bdq_pkg::CMD_CLEAR: begin
                    n_front = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
        op_res.entry_count = bdq_pkg::COUNT_W'(n_count);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (cmd == bdq_pkg::CMD_SEARCH) ? bdq_pkg::S_SCAN
                                                           : bdq_pkg::S_RESP;
                end
            end
            bdq_pkg::S_SCAN: begin
                if (hit || !more) begin
                    n_state = bdq_pkg::S_RESP;
                end
            end
            bdq_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = bdq_pkg::S_IDLE;
                end
            end
            default: n_state = bdq_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = (r_state == bdq_pkg::S_IDLE);
        o_mem_re    = (r_state == bdq_pkg::S_SCAN) && !hit && more;
        o_mem_raddr = ring_add(r_front, r_iss);
        out_load    = (r_state == bdq_pkg::S_RESP) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bdq_pkg::S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_cmp_v  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (accept) begin
                r_cmp_v <= 1'b0;
            end else if (r_state == bdq_pkg::S_SCAN) begin
                r_cmp_v <= o_mem_re;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // search key, scan pointers and result words
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= in_word;
            r_iss  <= '0;
            if (cmd != bdq_pkg::CMD_SEARCH) begin
                r_res <= op_res;
            end
        end else if (r_state == bdq_pkg::S_SCAN) begin
            if (o_mem_re) begin
                r_iss  <= r_iss + 1'b1;
                r_cpos <= IW'(r_iss);
            end
            if (hit) begin
                r_res <= '{found: 1'b1,
                           match_position: bdq_pkg::POS_W'(r_cpos),
                           entry_count: bdq_pkg::COUNT_W'(r_count),
                           status: bdq_pkg::ST_DONE};
            end else if (!more) begin
                r_res <= '{found: 1'b0, match_position: '0,
                           entry_count: bdq_pkg::COUNT_W'(r_count),
                           status: bdq_pkg::ST_DONE};
            end
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.found          = r_out.found;
    assign o_rsp.match_position = r_out.match_position;
    assign o_rsp.entry_count    = r_out.entry_count;
    assign o_rsp.status         = r_out.status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_scan_holds_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bdq_pkg::S_SCAN) |=> $stable(r_front) && $stable(r_count))
        else $error("ring moved during search");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == bdq_pkg::S_IDLE))
        else $error("memory write outside idle");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bdq_pkg::S_SCAN) && hit) |-> (CW'(r_cpos) < r_count))
        else $error("match beyond held entries");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> r_ovalid && $stable(r_out))
        else $error("stalled result overwritten");

endmodule

// File: rtl/core/bounded_deque_with_search_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Bounded double-ended queue of signed words with a linear search.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request word (cmd, item_value); o_rsp returns exactly
//   one result word (found, match_position, entry_count, status) for each.
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   Push, pop and clear update the ring on acceptance, and unused codes leave
//   it unchanged; their result is registered in the controller and then in
//   the output register, and i_req is ready again once that result has been
//   loaded into the output register. A search reads the entry memory one entry
//   per cycle from the front through its single read port and stops at the
//   first match or after the last held entry before its result is offered.
//   One request is in work at a time; the output register holds a finished
//   result while the next request is taken.
//   If the receiver stalls, the result is held and a further finished result
//   waits in the controller until the output register empties.
//   Reset empties the deque (front index and count to zero); memory contents
//   are not cleared and are only ever read once written.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdq_req_if.sink     i_req,
    bdq_rsp_if.source   o_rsp
);

    localparam int IW = $clog2(DEPTH);

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [IW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    bdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    bdq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
